### rtl/core/ali_pkg.sv
// Shared constants, codes and controller-to-datapath types for the array list block.
`default_nettype none
package ali_pkg;

   localparam int CAPACITY = 16;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 8;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_POP    = 3'd2,
      OP_REMOVE = 3'd3,
      OP_READ   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef struct packed {
      logic              exec;
      logic [2:0]        op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] din;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/core/ali_ctrl.sv
// Controller that accepts a request, holds it and starts its execution in the datapath.
`default_nettype none
module ali_ctrl import ali_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [2:0]        req_op,
   input  wire logic [POS_W-1:0]  req_pos,
   input  wire logic [DATA_W-1:0] req_din,
   input  wire dp_status_type     dp_status,
   output dp_cmd_type             dp_cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] din_ff, din_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      pos_in   = pos_ff;
      din_in   = din_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
               op_in    = req_op;
               pos_in   = req_pos;
               din_in   = req_din;
            end
         end
         S_EXEC: begin
            if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      pos_ff <= pos_in;
      din_ff <= din_in;
   end

   assign req_tready  = (state_ff == S_IDLE);
   assign dp_cmd.exec = (state_ff == S_EXEC) && dp_status.out_free;
   assign dp_cmd.op   = op_ff;
   assign dp_cmd.pos  = pos_ff;
   assign dp_cmd.din  = din_ff;

endmodule
`default_nettype wire

### rtl/core/ali_dpath.sv
// Datapath with the entry cells, the entry count and the response register.
`default_nettype none
module ali_dpath import ali_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type dp_cmd,
   output dp_status_type   dp_status,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [1:0]      rsp_tuser,
   output logic [15:0]     rsp_tdata
);

   logic [DATA_W-1:0] cells_ff [CAPACITY];
   logic [DATA_W-1:0] cells_in [CAPACITY];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              valid_ff, valid_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] dout_ff, dout_in;
   logic [POS_W-1:0]  cnt_out_ff, cnt_out_in;
   logic              empty_ff, empty_in, full_ff, full_in;

   logic [CMP_W-1:0]  pos_w, cnt_w, rd_idx, cnt_next_w;
   logic [DATA_W-1:0] rd_data;
   logic              is_full, is_empty, app_ok, ins_ok, rem_ok;

   assign pos_w    = CMP_W'(dp_cmd.pos);
   assign cnt_w    = CMP_W'(count_ff);
   assign is_full  = (cnt_w >= CMP_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign rd_idx   = (dp_cmd.op == OP_POP) ? (cnt_w - CMP_W'(1)) : pos_w;
   assign rd_data  = cells_ff[rd_idx[IDX_W-1:0]];

   always_comb begin
      status_in = ST_OK;
      dout_in   = '0;
      count_in  = count_ff;
      app_ok    = 1'b0;
      ins_ok    = 1'b0;
      rem_ok    = 1'b0;
      unique case (dp_cmd.op)
         OP_APPEND: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               app_ok   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else if (pos_w > cnt_w) begin
               status_in = ST_BADPOS;
            end else begin
               ins_ok   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               dout_in  = rd_data;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else if (pos_w >= cnt_w) begin
               status_in = ST_BADPOS;
            end else begin
               rem_ok   = 1'b1;
               dout_in  = rd_data;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else if (pos_w >= cnt_w) begin
               status_in = ST_BADPOS;
            end else begin
               dout_in = rd_data;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (app_ok && (CMP_W'(i) == cnt_w)) begin
            cells_in[i] = dp_cmd.din;
         end else if (ins_ok && (CMP_W'(i) > pos_w)) begin
            cells_in[i] = cells_ff[(i == 0) ? 0 : i - 1];
         end else if (ins_ok && (CMP_W'(i) == pos_w)) begin
            cells_in[i] = dp_cmd.din;
         end else if (rem_ok && (CMP_W'(i) >= pos_w) && (i < CAPACITY - 1)) begin
            cells_in[i] = cells_ff[(i >= CAPACITY - 1) ? i : i + 1];
         end
      end
   end

   assign cnt_next_w = CMP_W'(count_in);
   assign cnt_out_in = cnt_next_w[POS_W-1:0];
   assign empty_in   = (count_in == '0);
   assign full_in    = (cnt_next_w >= CMP_W'(CAPACITY));
   assign valid_in   = dp_cmd.exec ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (dp_cmd.exec) begin
            count_ff <= count_in;
         end
      end
      if (dp_cmd.exec) begin
         cells_ff   <= cells_in;
         status_ff  <= status_in;
         dout_ff    <= dout_in;
         cnt_out_ff <= cnt_out_in;
         empty_ff   <= empty_in;
         full_ff    <= full_in;
      end
   end

   assign dp_status.out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid         = valid_ff;
   assign rsp_tuser          = status_ff;
   assign rsp_tdata          = {1'b0, full_ff, empty_ff, cnt_out_ff, dout_ff};

endmodule
`default_nettype wire

### rtl/core/array_list_insert_remove_top.sv
// Top level of the bounded array list: request channel, controller, datapath, response channel.
// A request is accepted in the idle state and executed once the response register is free.
// The response is registered in the datapath when the held request executes.
// The controller accepts no new request until the held request has executed.
// A waiting response stalls execution of the held request only; one request can be held.
// Synchronous reset empties the list and clears the response valid; cells are not cleared.
`default_nettype none
module array_list_insert_remove_top import ali_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,   // req_type
   input  wire logic [15:0] req_tdata,   // position[4:0], data_in[12:5], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // status
   output logic [15:0]      rsp_tdata    // data_out, entry_count, is_empty, is_full, zero pad
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ali_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_pos    (req_tdata[POS_W-1:0]),
      .req_din    (req_tdata[POS_W+DATA_W-1:POS_W]),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   ali_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

### rtl/core/ali_chk.sv
// Port-level checker for the array list top level, with its bind statement.
`default_nettype none
module ali_chk import ali_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [1:0]  rsp_tuser,
   input wire logic [15:0] rsp_tdata
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13] == (rsp_tdata[12:8] == 5'd0)))
      else $error("empty flag disagrees with count");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("data not zero on failed request");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("response missing after request");

endmodule

bind array_list_insert_remove_top ali_chk u_ali_chk (.*);
`default_nettype wire
